@@ hw/rtl/kwd_pkg.sv @@
// Shared types, register map, keys and defaults for the keyed watchdog.
package kwd_pkg;

  localparam int RESET_LINES_DEF    = 16;
  localparam int TICKS_PER_UNIT_DEF = 512;
  localparam int MAX_LINES          = 24;

  localparam int MODE_W  = 7;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = 20;
  localparam int OUT_LINES_W = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = '1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [7:0] OFS_MODE     = 8'h00;
  localparam logic [7:0] OFS_LENGTH   = 8'h04;
  localparam logic [7:0] OFS_RST      = 8'h08;
  localparam logic [7:0] OFS_SWRST    = 8'h14;
  localparam logic [7:0] OFS_SWSYSRST = 8'h18;

  localparam logic [7:0]  MODE_KEY     = 8'h22;
  localparam logic [4:0]  LENGTH_KEY   = 5'h08;
  localparam logic [31:0] RELOAD_VALUE = 32'h0000_1971;
  localparam logic [31:0] SWRST_VALUE  = 32'h0000_1209;
  localparam logic [7:0]  SYSRST_KEY   = 8'h88;

  localparam int MODE_EN_BIT  = 0;
  localparam int MODE_IRQ_BIT = 3;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_SW      = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  reg_offset;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        chip_reset;
    logic        irq_level;
    logic [1:0]  reset_cause;
    logic [15:0] block_resets;
  } out_t;

endpackage

@@ hw/rtl/kwd_core.sv @@
// Watchdog register file, countdown and result logic for one transfer.
module kwd_core import kwd_pkg::*; #(
  parameter int RESET_LINES    = RESET_LINES_DEF,
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic item_en,
  input  in_t  item,
  output out_t result
);

  localparam int TPU_W  = $clog2(TICKS_PER_UNIT + 1);
  localparam int PROD_W = LEN_W + TPU_W;
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(int'(LEN_RESET) * TICKS_PER_UNIT);

  logic [MODE_W-1:0]      mode_r, mode_nxt;
  logic [LEN_W-1:0]       length_r, length_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   irq_r, irq_nxt;
  logic [RESET_LINES-1:0] lines_r, lines_nxt;

  logic [PROD_W-1:0]    prod;
  logic [CNT_W-1:0]     reload;
  logic [MAX_LINES-1:0] lines_ext;
  logic [31:0]          rd;
  logic                 rst_pulse;
  logic [1:0]           cause;

  assign prod   = PROD_W'(length_r) * PROD_W'(TICKS_PER_UNIT);
  assign reload = CNT_W'(prod);

  always_comb begin
    mode_nxt   = mode_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    irq_nxt    = irq_r;
    lines_nxt  = lines_r;
    rd         = '0;
    rst_pulse  = 1'b0;
    cause      = CAUSE_NONE;
    case (item.cmd)
      CMD_WRITE: begin
        case (item.reg_offset)
          OFS_MODE: begin
            if (item.write_data[31:24] == MODE_KEY) begin
              mode_nxt = item.write_data[MODE_W-1:0];
            end
          end
          OFS_LENGTH: begin
            if (item.write_data[4:0] == LENGTH_KEY) begin
              length_nxt = item.write_data[LEN_W+4:5];
            end
          end
          OFS_RST: begin
            if (item.write_data == RELOAD_VALUE) begin
              count_nxt = reload;
              irq_nxt   = 1'b0;
            end
          end
          OFS_SWRST: begin
            if (item.write_data == SWRST_VALUE) begin
              rst_pulse = 1'b1;
              cause     = CAUSE_SW;
            end
          end
          OFS_SWSYSRST: begin
            if (item.write_data[31:24] == SYSRST_KEY) begin
              lines_nxt = item.write_data[RESET_LINES-1:0];
            end
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        case (item.reg_offset)
          OFS_MODE:     rd = 32'(mode_r);
          OFS_LENGTH:   rd = 32'({length_r, 5'b0});
          OFS_SWSYSRST: rd = 32'(lines_r);
          default:      rd = '0;
        endcase
      end
      CMD_TICK: begin
        if (mode_r[MODE_EN_BIT]) begin
          if (count_r <= CNT_W'(1)) begin
            count_nxt = reload;
            if (mode_r[MODE_IRQ_BIT]) begin
              irq_nxt = 1'b1;
            end else begin
              rst_pulse = 1'b1;
              cause     = CAUSE_TIMEOUT;
            end
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign lines_ext = MAX_LINES'(lines_nxt);

  always_comb begin
    result.read_data    = rd;
    result.chip_reset   = rst_pulse;
    result.irq_level    = irq_nxt;
    result.reset_cause  = cause;
    result.block_resets = lines_ext[OUT_LINES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      length_r <= LEN_RESET;
      count_r  <= CNT_RESET;
      irq_r    <= 1'b0;
      lines_r  <= '0;
    end else if (item_en) begin
      mode_r   <= mode_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      irq_r    <= irq_nxt;
      lines_r  <= lines_nxt;
    end
  end

endmodule

@@ hw/rtl/keyed_watchdog_with_reset_lines.sv @@
// Top level: input register, watchdog core and result register.
// Keyed watchdog with software reset lines. Each input transfer is one bus
// write, bus read or timer tick, and yields exactly one result transfer. The
// block takes one transfer per clock while the result register is not held;
// each result passes from the input register, through the register file
// logic, into the result register. out_stall holds the result register and,
// through it, the input register, so throughput follows the downstream side.
// The countdown reloads to length * TICKS_PER_UNIT and starts at its maximum
// after reset with the watchdog disabled.
module keyed_watchdog_with_reset_lines import kwd_pkg::*; #(
  parameter int RESET_LINES    = RESET_LINES_DEF,
  parameter int TICKS_PER_UNIT = TICKS_PER_UNIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic in_valid_r;
  in_t  in_r;
  logic out_valid_r;
  out_t out_r;
  out_t result;
  logic advance;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  kwd_core #(
    .RESET_LINES    (RESET_LINES),
    .TICKS_PER_UNIT (TICKS_PER_UNIT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (in_valid_r && advance),
    .item    (in_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_r <= result;
    end
  end

endmodule
